// ===== rtl/core/ceb_pkg.sv =====
// ----------------------------------------------------------------------------
// ceb_pkg
// Shared types and defaults of the coincidence event builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ceb_pkg;

  localparam int unsigned NumGroupsDef    = 8;
  localparam int unsigned QueueDepthDef   = 16;
  localparam int unsigned MaxEventHitsDef = 64;

  localparam int unsigned TimeW = 48;
  localparam int unsigned PayW  = 64;
  localparam int unsigned WinW  = 32;

  // request codes on the input
  localparam logic [1:0] REQ_HIT = 2'd0;
  localparam logic [1:0] REQ_END = 2'd1;

  // register indexes
  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_ENABLE = 1'b1;

  // result kinds
  localparam logic RES_HIT    = 1'b0;
  localparam logic RES_NOTICE = 1'b1;

  typedef enum logic [1:0] {
    CMD_HIT,
    CMD_END,
    CMD_DRAIN
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [2:0]         grp;
    logic [TimeW-1:0]   time_v;
    logic [PayW-1:0]    pay;
  } cmd_t;

  typedef struct packed {
    logic               valid;
    logic               kind;
    logic [31:0]        evn;
    logic [5:0]         idx;
    logic [TimeW-1:0]   time_v;
    logic [PayW-1:0]    pay;
    logic               last;
    logic               trunc;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/ceb_front.sv =====
// ----------------------------------------------------------------------------
// ceb_front
// Accepts requests, classifies them and packs them for the command queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ceb_front #(
  parameter int unsigned NUM_GROUPS = ceb_pkg::NumGroupsDef
) (
  input  wire logic                      start,
  input  wire logic                      full_i,
  input  wire logic [1:0]                req_type_i,
  input  wire logic [2:0]                source_group_i,
  input  wire logic [ceb_pkg::TimeW-1:0] hit_time_i,
  input  wire logic [15:0]               board_serial_i,
  input  wire logic [7:0]                channel_number_i,
  input  wire logic [14:0]               energy_long_i,
  input  wire logic [14:0]               energy_short_i,
  input  wire logic [9:0]                fine_time_i,
  output logic                           push_o,
  output ceb_pkg::cmd_t                  cmd_o
);

  logic in_range;

  // groups beyond the configured count only trigger a build attempt
  assign in_range = ({3'b000, source_group_i} < 6'(NUM_GROUPS));
  assign push_o   = start && !full_i;

  always_comb begin
    cmd_o.grp    = source_group_i;
    cmd_o.time_v = hit_time_i;
    cmd_o.pay    = {board_serial_i, channel_number_i, energy_long_i,
                    energy_short_i, fine_time_i};
    if (in_range && req_type_i == ceb_pkg::REQ_HIT) begin
      cmd_o.kind = ceb_pkg::CMD_HIT;
    end else if (in_range && req_type_i == ceb_pkg::REQ_END) begin
      cmd_o.kind = ceb_pkg::CMD_END;
    end else begin
      cmd_o.kind = ceb_pkg::CMD_DRAIN;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ceb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// ceb_cmd_fifo
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ceb_cmd_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire ceb_pkg::cmd_t data_i,
  input  wire logic          pop_i,
  output ceb_pkg::cmd_t      data_o,
  output logic               empty_o,
  output logic               full_o
);

  ceb_pkg::cmd_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];

  // advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  // hold queued requests
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule
`default_nettype wire

// ===== rtl/core/ceb_back.sv =====
// ----------------------------------------------------------------------------
// ceb_back
// Per-group hit queues, earliest-head search and event building sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ceb_back #(
  parameter int unsigned NUM_GROUPS     = ceb_pkg::NumGroupsDef,
  parameter int unsigned QUEUE_DEPTH    = ceb_pkg::QueueDepthDef,
  parameter int unsigned MAX_EVENT_HITS = ceb_pkg::MaxEventHitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     empty_i,
  input  wire ceb_pkg::cmd_t            cmd_i,
  output logic                          pop_o,
  input  wire logic [ceb_pkg::WinW-1:0] win_i,
  input  wire logic                     en_i,
  output ceb_pkg::res_t                 res_o
);

  localparam int unsigned GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned FW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW = $clog2(NUM_GROUPS * QUEUE_DEPTH);
  localparam int unsigned NW = $clog2(MAX_EVENT_HITS + 1);
  localparam int unsigned TW = ceb_pkg::TimeW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_CHECK, ST_POP, ST_POP2, ST_FLUSH
  } state_e;

  state_e              state_q;
  ceb_pkg::cmd_t       cmd_q;
  logic [FW-1:0]       fill_q [NUM_GROUPS];
  logic [PW-1:0]       rp_q   [NUM_GROUPS];
  logic [PW-1:0]       wp_q   [NUM_GROUPS];
  logic [TW-1:0]       head_q [NUM_GROUPS];
  logic [TW-1:0]       tail_q [NUM_GROUPS];
  logic                ended_q [NUM_GROUPS];
  logic [31:0]         evn_q;
  logic [GW-1:0]       idx_q, best_g_q, gsel;
  logic                best_v_q, first_q;
  logic [TW-1:0]       best_t_q;
  logic [TW:0]         limit_q;
  logic [NW-1:0]       n_q;
  logic                trunc_q, pend_v_q;
  logic [TW-1:0]       pend_t_q;
  logic [63:0]         pend_p_q;
  ceb_pkg::res_t       res_q;

  logic [TW-1:0]       mem_time [NUM_GROUPS * QUEUE_DEPTH];
  logic [63:0]         mem_pay  [NUM_GROUPS * QUEUE_DEPTH];
  logic [TW-1:0]       rd_time_q;
  logic [63:0]         rd_pay_q;
  logic                wr_en, rd_en;
  logic [AW-1:0]       wr_addr, rd_addr_p, rd_addr_t;
  logic [PW-1:0]       rp_sel, rp_next;

  logic                cand, nb_v, idx_last, chk_fail;
  logic [GW-1:0]       nb_g;
  logic [TW-1:0]       nb_t;

  assign gsel     = GW'(cmd_q.grp);
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign res_o    = res_q;
  assign idx_last = (idx_q == GW'(NUM_GROUPS - 1));

  // memory addressing
  assign rp_sel    = rp_q[best_g_q];
  assign rp_next   = (rp_sel == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_sel + 1'b1;
  assign wr_en     = (state_q == ST_EXEC) && (cmd_q.kind == ceb_pkg::CMD_HIT) &&
                     (fill_q[gsel] != FW'(QUEUE_DEPTH));
  assign rd_en     = (state_q == ST_POP);
  assign wr_addr   = AW'(32'(gsel) * QUEUE_DEPTH + 32'(wp_q[gsel]));
  assign rd_addr_p = AW'(32'(best_g_q) * QUEUE_DEPTH + 32'(rp_sel));
  assign rd_addr_t = AW'(32'(best_g_q) * QUEUE_DEPTH + 32'(rp_next));

  // one step of the earliest-head scan
  always_comb begin
    cand = (fill_q[idx_q] != '0) && (!best_v_q || head_q[idx_q] < best_t_q);
    nb_v = best_v_q || (fill_q[idx_q] != '0);
    nb_g = cand ? idx_q : best_g_q;
    nb_t = cand ? head_q[idx_q] : best_t_q;
  end

  // one step of the readiness check
  always_comb begin
    chk_fail = 1'b0;
    if (!ended_q[idx_q]) begin
      if (!en_i) begin
        chk_fail = (fill_q[idx_q] == '0);
      end else if (fill_q[idx_q] != FW'(QUEUE_DEPTH)) begin
        chk_fail = (fill_q[idx_q] == '0) || ({1'b0, tail_q[idx_q]} <= limit_q);
      end
    end
  end

  // hit storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_time[wr_addr] <= cmd_q.time_v;
      mem_pay[wr_addr]  <= cmd_q.pay;
    end
    if (rd_en) begin
      rd_pay_q  <= mem_pay[rd_addr_p];
      rd_time_q <= mem_time[rd_addr_t];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cmd_q    <= '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
        fill_q[g]  <= '0;
        rp_q[g]    <= '0;
        wp_q[g]    <= '0;
        head_q[g]  <= '0;
        tail_q[g]  <= '0;
        ended_q[g] <= 1'b0;
      end
      evn_q    <= '0;
      idx_q    <= '0;
      best_g_q <= '0;
      best_v_q <= 1'b0;
      best_t_q <= '0;
      first_q  <= 1'b0;
      limit_q  <= '0;
      n_q      <= '0;
      trunc_q  <= 1'b0;
      pend_v_q <= 1'b0;
      pend_t_q <= '0;
      pend_p_q <= '0;
      res_q    <= '0;
    end else begin
      res_q.valid <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            cmd_q   <= cmd_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          idx_q    <= '0;
          best_v_q <= 1'b0;
          first_q  <= 1'b1;
          state_q  <= ST_SCAN;
          unique case (cmd_q.kind)
            ceb_pkg::CMD_HIT: begin
              if (fill_q[gsel] == FW'(QUEUE_DEPTH)) begin
                // drop on a full queue and send a notice
                res_q.valid  <= 1'b1;
                res_q.kind   <= ceb_pkg::RES_NOTICE;
                res_q.evn    <= evn_q;
                res_q.idx    <= '0;
                res_q.time_v <= cmd_q.time_v;
                res_q.pay    <= cmd_q.pay;
                res_q.last   <= 1'b0;
                res_q.trunc  <= 1'b0;
                state_q      <= ST_IDLE;
              end else begin
                if (fill_q[gsel] == '0) head_q[gsel] <= cmd_q.time_v;
                tail_q[gsel] <= cmd_q.time_v;
                fill_q[gsel] <= fill_q[gsel] + 1'b1;
                wp_q[gsel]   <= (wp_q[gsel] == PW'(QUEUE_DEPTH - 1)) ? '0 :
                                wp_q[gsel] + 1'b1;
              end
            end
            ceb_pkg::CMD_END: ended_q[gsel] <= 1'b1;
            default: ;
          endcase
        end
        ST_SCAN: begin
          best_v_q <= nb_v;
          best_g_q <= nb_g;
          best_t_q <= nb_t;
          idx_q    <= idx_q + 1'b1;
          if (idx_last) begin
            idx_q <= '0;
            if (first_q) begin
              if (!nb_v) begin
                state_q <= ST_IDLE;
              end else begin
                limit_q  <= {1'b0, nb_t} + (TW + 1)'(win_i);
                n_q      <= '0;
                trunc_q  <= 1'b0;
                pend_v_q <= 1'b0;
                state_q  <= ST_CHECK;
              end
            end else if (!nb_v || {1'b0, nb_t} > limit_q) begin
              state_q <= ST_FLUSH;
            end else begin
              state_q <= ST_POP;
            end
          end
        end
        ST_CHECK: begin
          idx_q <= idx_q + 1'b1;
          if (chk_fail) begin
            state_q <= ST_IDLE;
          end else if (idx_last) begin
            state_q <= ST_POP;
          end
        end
        ST_POP: state_q <= ST_POP2;
        ST_POP2: begin
          // advance the popped queue and refresh its head
          rp_q[best_g_q]   <= rp_next;
          fill_q[best_g_q] <= fill_q[best_g_q] - 1'b1;
          head_q[best_g_q] <= rd_time_q;
          if (!en_i) begin
            res_q.valid  <= 1'b1;
            res_q.kind   <= ceb_pkg::RES_HIT;
            res_q.evn    <= evn_q;
            res_q.idx    <= '0;
            res_q.time_v <= best_t_q;
            res_q.pay    <= rd_pay_q;
            res_q.last   <= 1'b1;
            res_q.trunc  <= 1'b0;
            evn_q        <= evn_q + 1'b1;
            state_q      <= ST_IDLE;
          end else begin
            if (n_q < NW'(MAX_EVENT_HITS)) begin
              if (pend_v_q) begin
                res_q.valid  <= 1'b1;
                res_q.kind   <= ceb_pkg::RES_HIT;
                res_q.evn    <= evn_q;
                res_q.idx    <= 6'(n_q - 1'b1);
                res_q.time_v <= pend_t_q;
                res_q.pay    <= pend_p_q;
                res_q.last   <= 1'b0;
                res_q.trunc  <= 1'b0;
              end
              pend_v_q <= 1'b1;
              pend_t_q <= best_t_q;
              pend_p_q <= rd_pay_q;
              n_q      <= n_q + 1'b1;
            end else begin
              trunc_q <= 1'b1;
            end
            idx_q    <= '0;
            best_v_q <= 1'b0;
            first_q  <= 1'b0;
            state_q  <= ST_SCAN;
          end
        end
        ST_FLUSH: begin
          // send the held hit as the last of the event
          res_q.valid  <= pend_v_q;
          res_q.kind   <= ceb_pkg::RES_HIT;
          res_q.evn    <= evn_q;
          res_q.idx    <= 6'(n_q - 1'b1);
          res_q.time_v <= pend_t_q;
          res_q.pay    <= pend_p_q;
          res_q.last   <= 1'b1;
          res_q.trunc  <= trunc_q;
          pend_v_q     <= 1'b0;
          evn_q        <= evn_q + 1'b1;
          state_q      <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_notice_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_q.valid && res_q.kind == ceb_pkg::RES_NOTICE |-> !res_q.last && !res_q.trunc)
    else $error("notice marked as end of event");
  a_flush_has_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FLUSH |-> pend_v_q)
    else $error("event closed without a held hit");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("request taken from an empty queue");
  a_pop_from_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_POP |-> fill_q[best_g_q] != '0)
    else $error("hit popped from an empty group");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/coincidence_event_builder_core.sv =====
// ----------------------------------------------------------------------------
// coincidence_event_builder_core
// Time-window coincidence event builder over per-group hit queues.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request (hit, end of stream or drain); it is taken
//   when busy is low. busy rises while the two-entry request queue is full.
//   Each result is shown for one cycle with result_valid_o high and must
//   be taken then; the receiver cannot stall.
//   Each request is applied in the execute state, then the groups are
//   scanned serially. A ready event adds a readiness check and, per popped
//   hit, a read and a queue update; with building on, a new scan follows
//   each pop and a flush state closes the event. The rate is set by the
//   serial earliest-head scan, one group per cycle. A hit to a full queue
//   is dropped with a notice from the execute state. Registers are written
//   through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them
//   only while the block is idle (not enforced). Reset empties all queues,
//   clears the event counter and sets the window to 100 and building on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module coincidence_event_builder_core #(
  parameter int unsigned NUM_GROUPS     = ceb_pkg::NumGroupsDef,
  parameter int unsigned QUEUE_DEPTH    = ceb_pkg::QueueDepthDef,
  parameter int unsigned MAX_EVENT_HITS = ceb_pkg::MaxEventHitsDef
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_idx_i,
  input  wire logic [31:0]   cfg_data_i,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    req_type_i,
  input  wire logic [2:0]    source_group_i,
  input  wire logic [47:0]   hit_time_i,
  input  wire logic [15:0]   board_serial_i,
  input  wire logic [7:0]    channel_number_i,
  input  wire logic [14:0]   energy_long_i,
  input  wire logic [14:0]   energy_short_i,
  input  wire logic [9:0]    fine_time_i,
  output logic               result_valid_o,
  output logic               result_kind_o,
  output logic [31:0]        event_number_o,
  output logic [5:0]         hit_index_o,
  output logic [47:0]        out_time_o,
  output logic [15:0]        out_board_o,
  output logic [7:0]         out_channel_o,
  output logic [14:0]        out_energy_long_o,
  output logic [14:0]        out_energy_short_o,
  output logic [9:0]         out_fine_time_o,
  output logic               last_of_event_o,
  output logic               event_truncated_o
);

  logic [31:0]   win_q;
  logic          en_q;
  logic          push, pop, empty;
  ceb_pkg::cmd_t cmd_in, cmd_out;
  ceb_pkg::res_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 32'd100;
      en_q  <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ceb_pkg::CFG_WINDOW) win_q <= cfg_data_i;
      if (cfg_idx_i == ceb_pkg::CFG_ENABLE) en_q  <= cfg_data_i[0];
    end
  end

  ceb_front #(.NUM_GROUPS(NUM_GROUPS)) u_front (
    .start            (start),
    .full_i           (busy),
    .req_type_i       (req_type_i),
    .source_group_i   (source_group_i),
    .hit_time_i       (hit_time_i),
    .board_serial_i   (board_serial_i),
    .channel_number_i (channel_number_i),
    .energy_long_i    (energy_long_i),
    .energy_short_i   (energy_short_i),
    .fine_time_i      (fine_time_i),
    .push_o           (push),
    .cmd_o            (cmd_in)
  );

  ceb_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty),
    .full_o  (busy)
  );

  ceb_back #(
    .NUM_GROUPS     (NUM_GROUPS),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .MAX_EVENT_HITS (MAX_EVENT_HITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .win_i   (win_q),
    .en_i    (en_q),
    .res_o   (res)
  );

  // unpack the result
  assign result_valid_o     = res.valid;
  assign result_kind_o      = res.kind;
  assign event_number_o     = res.evn;
  assign hit_index_o        = res.idx;
  assign out_time_o         = res.time_v;
  assign out_board_o        = res.pay[63:48];
  assign out_channel_o      = res.pay[47:40];
  assign out_energy_long_o  = res.pay[39:25];
  assign out_energy_short_o = res.pay[24:10];
  assign out_fine_time_o    = res.pay[9:0];
  assign last_of_event_o    = res.last;
  assign event_truncated_o  = res.trunc;

endmodule
`default_nettype wire
